// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define CCTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define CCTS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CCTS_ASSERT(lbl, clk, rstn, prop)
`define CCTS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/ccts_pkg.sv =====
// ---------------------------------------------------------------------------
// ccts_pkg
// Types and constants for the charge current table selector.
// ---------------------------------------------------------------------------
package ccts_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int IDX_W      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_VOLT  = 3'd1;
  localparam int                   REG_ENTRY_BASE  = 2;

  // selection code meaning nothing chosen yet
  localparam logic [IDX_W-1:0] NO_SEL = 3'd7;

  // hysteresis margins
  localparam int TEMP_MARGIN    = 2;
  localparam int VOLT_MARGIN_MV = 200;

  // one table entry, same layout as the register word
  typedef struct packed {
    logic signed [7:0] tmin;
    logic signed [7:0] tmax;
    logic [15:0]       volt;
    logic [15:0]       curr;
  } entry_t;

  // static configuration seen by the sequencer
  typedef struct packed {
    logic [IDX_W-1:0] count;
    logic [15:0]      float_mv;
  } cfg_view_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREV,
    ST_FINISH
  } state_t;

endpackage

// ===== design/charge_current_table_select_top.sv =====
// ---------------------------------------------------------------------------
// charge_current_table_select_top
// Battery charge current selection from a temperature/voltage window table.
// ---------------------------------------------------------------------------
// One sample is taken at a time. After the input beat the sequencer walks
// the table with a single window comparator, one entry per cycle, stopping
// at the first hit; the PREV state then reads the present entry for the
// hysteresis decision and FINISH loads the output register. A sample walks
// 1 to 6 entries, and a table disabled by an entry count of zero goes from
// the input beat straight to FINISH; the input is ready again once the
// result sits in the output register, and a result still waiting there
// stalls only the next result, not the next input beat.
module charge_current_table_select_top #(
  parameter int MAX_ENTRIES = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_wr_en,
  input  logic [ccts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // samples
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] temperature_c, [23:8] voltage_mv, [24] chg_present, rest zero
  input  logic [31:0]                     in_tdata,
  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] changed, [3:1] entry_index, [19:4] fcc_limit_ma, rest zero
  output logic [23:0]                     out_tdata
);

  `include "assert_macros.svh"

  ccts_pkg::state_t           state_r, state_nxt;
  ccts_pkg::cfg_view_t        view;
  ccts_pkg::entry_t           rd_entry;
  ccts_pkg::entry_t           pick_e_r;
  logic [ccts_pkg::IDX_W-1:0] rd_addr;
  logic [ccts_pkg::IDX_W-1:0] idx_r;
  logic [ccts_pkg::IDX_W-1:0] pick_r;
  logic [ccts_pkg::IDX_W-1:0] sel_r;
  logic [ccts_pkg::IDX_W-1:0] res_sel_r;
  logic                       res_changed_r;
  logic [15:0]                res_fcc_r;
  logic signed [7:0]          temp_r;
  logic [15:0]                volt_r;
  logic                       online_r;
  logic                       out_valid_r;
  logic                       out_changed_r;
  logic [ccts_pkg::IDX_W-1:0] out_index_r;
  logic [15:0]                out_fcc_r;
  logic                       accept;
  logic                       hit;
  logic                       held;
  logic                       last;
  logic                       take;
  logic                       out_load;
  logic [15:0]                in_volt;

  // table storage
  ccts_regs #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .rd_addr  (rd_addr),
    .view     (view),
    .rd_entry (rd_entry)
  );

  // shared window comparator
  ccts_match u_match (
    .entry(rd_entry),
    .temp (temp_r),
    .volt (volt_r),
    .hit  (hit)
  );

  // hysteresis against the present entry
  ccts_hyst u_hyst (
    .next_e(pick_e_r),
    .pres_e(rd_entry),
    .temp  (temp_r),
    .volt  (volt_r),
    .held  (held)
  );

  assign in_volt = in_tdata[23:8];
  assign accept  = in_tvalid && in_tready;
  assign last    = (idx_r + 3'd1) == view.count;

  // take decision: new pick differs and no hysteresis hold applies
  assign take = (pick_r != sel_r) &&
                ((sel_r >= view.count) || (pick_e_r.curr <= rd_entry.curr) ||
                 !online_r || !held);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccts_pkg::ST_IDLE: begin
        if (accept) begin
          if (view.count == '0) begin
            state_nxt = ccts_pkg::ST_FINISH;
          end else begin
            state_nxt = ccts_pkg::ST_SCAN;
          end
        end
      end
      ccts_pkg::ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ccts_pkg::ST_PREV;
        end
      end
      ccts_pkg::ST_PREV: begin
        state_nxt = ccts_pkg::ST_FINISH;
      end
      ccts_pkg::ST_FINISH: begin
        if (out_load) begin
          state_nxt = ccts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccts_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = idx_r;
    out_load  = 1'b0;
    case (state_r)
      ccts_pkg::ST_IDLE:   in_tready = 1'b1;
      ccts_pkg::ST_SCAN:   rd_addr   = idx_r;
      ccts_pkg::ST_PREV:   rd_addr   = sel_r;
      ccts_pkg::ST_FINISH: out_load  = !out_valid_r || out_tready;
      default:             in_tready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccts_pkg::ST_IDLE;
      sel_r       <= ccts_pkg::NO_SEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        sel_r       <= res_sel_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ccts_pkg::ST_IDLE: begin
        if (accept) begin
          temp_r        <= $signed(in_tdata[7:0]);
          volt_r        <= (in_volt > view.float_mv) ? view.float_mv : in_volt;
          online_r      <= in_tdata[24];
          idx_r         <= '0;
          res_changed_r <= 1'b0;
          res_sel_r     <= sel_r;
          res_fcc_r     <= '0;
        end
      end
      ccts_pkg::ST_SCAN: begin
        if (hit) begin
          pick_r   <= idx_r;
          pick_e_r <= rd_entry;
        end else if (last) begin
          // no match: selection is the entry count, current zero
          pick_r   <= view.count;
          pick_e_r <= '0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
      ccts_pkg::ST_PREV: begin
        res_changed_r <= take;
        res_sel_r     <= take ? pick_r : sel_r;
        res_fcc_r     <= take ? pick_e_r.curr : 16'd0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_changed_r <= res_changed_r;
      out_index_r   <= res_sel_r;
      out_fcc_r     <= res_fcc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_fcc_r, out_index_r, out_changed_r};

  // checks
  `CCTS_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ccts_pkg::ST_FINISH))
  `CCTS_ASSERT(a_sel_on_finish, clk, rst_n, !$stable(sel_r) |-> $past(state_r == ccts_pkg::ST_FINISH))
  `CCTS_ASSERT_NEVER(a_scan_bound, clk, rst_n, (state_r == ccts_pkg::ST_SCAN) && (idx_r >= view.count))
  `CCTS_ASSERT(a_change_moves, clk, rst_n, (out_load && res_changed_r) |-> (res_sel_r != sel_r))

endmodule

// ===== design/ccts_regs.sv =====
// ---------------------------------------------------------------------------
// ccts_regs
// Configuration registers and the single entry read port of the table.
// ---------------------------------------------------------------------------
module ccts_regs #(
  parameter int MAX_ENTRIES = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ccts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [ccts_pkg::IDX_W-1:0]      rd_addr,
  output ccts_pkg::cfg_view_t             view,
  output ccts_pkg::entry_t                rd_entry
);

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW     = ccts_pkg::CFG_IDX_W;

  logic [ccts_pkg::IDX_W-1:0] count_r;
  logic [15:0]                float_r;
  ccts_pkg::entry_t           entry_r [MAX_ENTRIES];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      float_r <= '0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        entry_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == ccts_pkg::REG_ENTRY_COUNT) begin
        count_r <= cfg_wdata[ccts_pkg::IDX_W-1:0];
      end
      if (cfg_index == ccts_pkg::REG_FLOAT_VOLT) begin
        float_r <= cfg_wdata[15:0];
      end
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        if (cfg_index == IW'(ccts_pkg::REG_ENTRY_BASE + k)) begin
          entry_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // count above the table size acts as the table size
  always_comb begin
    view.float_mv = float_r;
    if (count_r > MAX_ENTRIES) begin
      view.count = ccts_pkg::IDX_W'(MAX_ENTRIES);
    end else begin
      view.count = count_r;
    end
  end

  // entry read, zero beyond the table
  always_comb begin
    if (rd_addr < MAX_ENTRIES) begin
      rd_entry = entry_r[rd_addr[ADDR_W-1:0]];
    end else begin
      rd_entry = '0;
    end
  end

endmodule

// ===== design/ccts_match.sv =====
// ---------------------------------------------------------------------------
// ccts_match
// Shared window compare: does one entry accept the sample?
// ---------------------------------------------------------------------------
module ccts_match (
  input  ccts_pkg::entry_t  entry,
  input  logic signed [7:0] temp,
  input  logic [15:0]       volt,
  output logic              hit
);

  // temperature in [tmin, tmax) and clamped voltage within the limit
  assign hit = (temp >= entry.tmin) && (temp < entry.tmax) && (volt <= entry.volt);

endmodule

// ===== design/ccts_hyst.sv =====
// ---------------------------------------------------------------------------
// ccts_hyst
// Hysteresis check holding back a current rise near a window edge.
// ---------------------------------------------------------------------------
module ccts_hyst (
  input  ccts_pkg::entry_t  next_e,
  input  ccts_pkg::entry_t  pres_e,
  input  logic signed [7:0] temp,
  input  logic [15:0]       volt,
  output logic              held
);

  logic               same_win;
  logic signed [17:0] volt_s;
  logic signed [17:0] vlim_lo;
  logic signed [9:0]  temp_s;
  logic signed [9:0]  tmax_lo;
  logic signed [9:0]  tmin_hi;

  always_comb begin
    same_win = (next_e.tmin == pres_e.tmin) && (next_e.tmax == pres_e.tmax);
    volt_s   = $signed({2'b00, volt});
    vlim_lo  = $signed({2'b00, next_e.volt}) - 18'(ccts_pkg::VOLT_MARGIN_MV);
    temp_s   = 10'(temp);
    tmax_lo  = 10'(next_e.tmax) - 10'(ccts_pkg::TEMP_MARGIN);
    tmin_hi  = 10'(next_e.tmin) + 10'(ccts_pkg::TEMP_MARGIN);
    // same windows: voltage margin, else temperature margin on both edges
    if (same_win) begin
      held = volt_s > vlim_lo;
    end else begin
      held = (temp_s > tmax_lo) || (temp_s < tmin_hi);
    end
  end

endmodule

// ===== tb/charge_current_table_select_top_tb.sv =====
// ---------------------------------------------------------------------------
// charge_current_table_select_top_tb
// Self-checking bench for the charge current table selector.
// ---------------------------------------------------------------------------
// Battery samples are pushed through the stream input by a queue-fed driver.
// Each accepted beat is run through a local selection predictor (window walk,
// voltage clamp, hysteresis) and the expected result is queued. A monitor
// compares every output beat with the oldest expectation, field by field.
// A short directed sequence on a fixed charge table is followed by random
// samples over several tables and configurations, under varied back-pressure.
module charge_current_table_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 6;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;
  localparam int STALL_LIMIT = 3000;

  // input beat, lowest field in the lowest bits
  typedef struct packed {
    logic              chg_present;
    logic [15:0]       voltage_mv;
    logic signed [7:0] temperature_c;
  } sample_t;

  // output beat, lowest field in the lowest bits
  typedef struct packed {
    logic [15:0]                fcc_limit_ma;
    logic [ccts_pkg::IDX_W-1:0] entry_index;
    logic                       changed;
  } selection_t;

  typedef enum int {FLOAT_TOP_TIER, FLOAT_ZERO, FLOAT_FULL} float_mode_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wr_en  = 1'b0;
  logic [ccts_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [ccts_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [23:0]                     out_tdata;

  // predictor copy of registers and state
  logic [2:0]                 count_reg = '0;
  logic [15:0]                float_reg = '0;
  ccts_pkg::entry_t           table_reg [TABLE_DEPTH] = '{default: '0};
  logic [ccts_pkg::IDX_W-1:0] cur_sel   = ccts_pkg::NO_SEL;

  sample_t    sample_q [$];
  selection_t selection_q [$];
  sample_t    beat_cur;
  selection_t seen_sel;
  selection_t want_sel;

  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_ack  = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int errors       = 0;
  int beats_in     = 0;
  int tables_used  = 0;
  int sel_changes  = 0;
  int rises_held   = 0;
  int no_match     = 0;

  int gap_plan   [4] = '{0, 48, 0, 6};
  int stall_plan [4] = '{0, 0, 48, 6};
  int count_plan [PHASES] = '{6, 1, 7, 4, 6, 2, 5, 6};

  charge_current_table_select_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // selection predictor: updates cur_sel and returns the expected beat
  function automatic selection_t select_charge_current(sample_t s);
    int               lim;
    int               temp;
    int               volt;
    int               fcc;
    int               pick;
    bit               take;
    ccts_pkg::entry_t nxt;
    ccts_pkg::entry_t cur;
    selection_t       r;
    lim  = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    temp = int'($signed(s.temperature_c));
    volt = int'(s.voltage_mv);
    fcc  = 0;
    take = 1'b0;
    nxt  = '0;
    r.changed      = 1'b0;
    r.entry_index  = cur_sel;
    r.fcc_limit_ma = '0;
    if (lim == 0) return r;
    if (volt > int'(float_reg)) volt = int'(float_reg);
    // first entry whose window holds the sample
    for (pick = 0; pick < lim; pick++) begin
      nxt = table_reg[pick];
      if (temp >= int'($signed(nxt.tmin)) && temp < int'($signed(nxt.tmax)) &&
          volt <= int'(nxt.volt)) begin
        fcc = int'(nxt.curr);
        break;
      end
    end
    if (pick == lim) no_match++;
    if (pick == int'(cur_sel)) return r;
    if (int'(cur_sel) >= lim) begin
      take = 1'b1;
    end else begin
      cur = table_reg[cur_sel];
      if (fcc <= int'(cur.curr) || !s.chg_present) begin
        take = 1'b1;
      end else if (nxt.tmin == cur.tmin && nxt.tmax == cur.tmax) begin
        // same temperature band: hold within the voltage margin
        take = !(volt > int'(nxt.volt) - ccts_pkg::VOLT_MARGIN_MV);
      end else begin
        // different band: hold near either temperature edge
        take = !(temp > int'($signed(nxt.tmax)) - ccts_pkg::TEMP_MARGIN ||
                 temp < int'($signed(nxt.tmin)) + ccts_pkg::TEMP_MARGIN);
      end
      if (!take) rises_held++;
    end
    if (take) begin
      cur_sel        = pick[ccts_pkg::IDX_W-1:0];
      r.changed      = 1'b1;
      r.entry_index  = cur_sel;
      r.fcc_limit_ma = fcc[15:0];
      sel_changes++;
    end
    return r;
  endfunction

  // random sample, mostly aimed at a table window
  function automatic sample_t make_sample();
    sample_t          s;
    ccts_pkg::entry_t e;
    logic [31:0]      raw;
    int               span;
    int               t;
    int               v;
    if ($urandom_range(99) < 15) begin
      raw = $urandom();
      s   = raw[24:0];
    end else begin
      e    = table_reg[$urandom_range(TABLE_DEPTH - 1)];
      span = int'($signed(e.tmax)) - int'($signed(e.tmin));
      if (span < 0) span = 0;
      t = int'($signed(e.tmin)) - 3 + int'($urandom_range(span + 5));
      v = int'(e.volt) - 300 + int'($urandom_range(400));
      if (t > 127) t = 127;
      if (t < -128) t = -128;
      if (v > 65535) v = 65535;
      if (v < 0) v = 0;
      s.temperature_c = t[7:0];
      s.voltage_mv    = v[15:0];
      s.chg_present   = ($urandom_range(9) != 0);
    end
    return s;
  endfunction

  function automatic ccts_pkg::entry_t make_entry(int tmin, int tmax, int volt, int curr);
    ccts_pkg::entry_t e;
    e.tmin = tmin[7:0];
    e.tmax = tmax[7:0];
    e.volt = volt[15:0];
    e.curr = curr[15:0];
    return e;
  endfunction

  task automatic queue_sample(int t, int v, bit on);
    sample_t s;
    s.temperature_c = t[7:0];
    s.voltage_mv    = v[15:0];
    s.chg_present   = on;
    sample_q.push_back(s);
  endtask

  // register write, mirrored into the predictor copy
  task automatic write_reg(logic [ccts_pkg::CFG_IDX_W-1:0] idx,
                           logic [ccts_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      ccts_pkg::REG_ENTRY_COUNT: count_reg = data[2:0];
      ccts_pkg::REG_FLOAT_VOLT:  float_reg = data[15:0];
      default: table_reg[int'(idx) - ccts_pkg::REG_ENTRY_BASE] = data[47:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // JEITA-style table: three bands of two voltage tiers, or raw random words
  task automatic program_table(int cnt, bit scrambled, float_mode_t fmode);
    ccts_pkg::entry_t e;
    logic [63:0]      raw;
    int               base;
    int               step;
    int               vlo;
    int               vhi;
    int               tlo;
    base = int'($urandom_range(30)) - 20;
    step = int'($urandom_range(20, 4));
    vlo  = 3600 + int'($urandom_range(400));
    vhi  = vlo + 100 + int'($urandom_range(300));
    write_reg(ccts_pkg::REG_ENTRY_COUNT, ccts_pkg::CFG_DATA_W'(cnt));
    case (fmode)
      FLOAT_TOP_TIER: write_reg(ccts_pkg::REG_FLOAT_VOLT, ccts_pkg::CFG_DATA_W'(vhi));
      FLOAT_ZERO:     write_reg(ccts_pkg::REG_FLOAT_VOLT, '0);
      default:        write_reg(ccts_pkg::REG_FLOAT_VOLT, ccts_pkg::CFG_DATA_W'(16'hFFFF));
    endcase
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (scrambled) begin
        raw = {$urandom(), $urandom()};
        e   = raw[47:0];
      end else begin
        tlo = base + (k / 2) * step;
        e   = make_entry(tlo, tlo + step, (k % 2 == 0) ? vlo : vhi,
                         int'($urandom_range(3000)));
      end
      write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + k), e);
    end
    tables_used++;
  endtask

  // wait until nothing is queued, offered or expected, then let it settle
  task automatic wait_idle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || selection_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic flag_mismatch(string what, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        selection_q.push_back(select_charge_current(beat_cur));
        beats_in++;
      end
      if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        beat_cur = sample_q.pop_front();
        in_tdata  <= {7'd0, beat_cur};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_sel = out_tdata[19:0];
      if (selection_q.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, got %h",
                 $time, seen_sel);
        errors++;
      end else begin
        want_sel = selection_q.pop_front();
        if (seen_sel.changed != want_sel.changed)
          flag_mismatch("changed", want_sel.changed, seen_sel.changed);
        if (seen_sel.entry_index != want_sel.entry_index)
          flag_mismatch("entry_index", want_sel.entry_index, seen_sel.entry_index);
        if (seen_sel.fcc_limit_ma != want_sel.fcc_limit_ma)
          flag_mismatch("fcc_limit_ma", want_sel.fcc_limit_ma, seen_sel.fcc_limit_ma);
      end
    end
  end

  // watchdog on cycles without any beat or write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset
    queue_sample(25, 3800, 1'b1);
    queue_sample(-128, 65535, 1'b0);
    wait_idle();

    // fixed charge table
    write_reg(ccts_pkg::REG_ENTRY_COUNT, ccts_pkg::CFG_DATA_W'(6));
    write_reg(ccts_pkg::REG_FLOAT_VOLT, ccts_pkg::CFG_DATA_W'(4400));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 0),
              make_entry(0, 10, 4400, 400));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 1),
              make_entry(10, 45, 4200, 2000));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 2),
              make_entry(10, 45, 4400, 1000));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 3),
              make_entry(45, 55, 4100, 600));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 4),
              make_entry(-10, 0, 4400, 200));
    write_reg(ccts_pkg::CFG_IDX_W'(ccts_pkg::REG_ENTRY_BASE + 5),
              make_entry(55, 60, 4000, 300));
    tables_used++;
    queue_sample(25, 3800, 1'b1);    // first pick from no selection
    queue_sample(25, 3800, 1'b1);    // same selection
    queue_sample(25, 4300, 1'b1);    // lower current taken at once
    queue_sample(25, 4100, 1'b1);    // rise held inside voltage margin
    queue_sample(25, 3900, 1'b1);    // rise taken below margin
    queue_sample(50, 3900, 1'b1);
    queue_sample(44, 3900, 1'b1);    // rise held near band edge
    queue_sample(44, 3900, 1'b0);    // charger absent: taken
    queue_sample(70, 3900, 1'b1);    // no entry matches
    queue_sample(25, 3800, 1'b1);    // from the no-match selection
    queue_sample(25, 65535, 1'b1);   // clamped to float voltage
    queue_sample(-128, 0, 1'b1);
    queue_sample(127, 65535, 1'b1);
    queue_sample(-5, 0, 1'b1);
    wait_idle();
    // shrink the table: present selection goes stale
    write_reg(ccts_pkg::REG_ENTRY_COUNT, ccts_pkg::CFG_DATA_W'(3));
    queue_sample(-5, 0, 1'b1);
    queue_sample(5, 4000, 1'b1);
    wait_idle();
    // count above the table depth
    write_reg(ccts_pkg::REG_ENTRY_COUNT, ccts_pkg::CFG_DATA_W'(7));
    queue_sample(57, 3000, 1'b1);
    wait_idle();
    write_reg(ccts_pkg::REG_ENTRY_COUNT, '0);
    queue_sample(25, 3800, 1'b1);
    wait_idle();

    // random tables under each back-pressure pattern
    for (int p = 0; p < PHASES; p++) begin
      gap_pct   = gap_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      program_table(count_plan[p], p == 5,
                    (p == 3) ? FLOAT_ZERO : (p == 5) ? FLOAT_FULL : FLOAT_TOP_TIER);
      for (int i = 0; i < PHASE_BEATS; i++) sample_q.push_back(make_sample());
      if (p == 0) hold_req = ~hold_req;
      wait_idle();
    end

    $display("Run covered %0d samples over %0d table settings: %0d selection changes,",
             beats_in, tables_used, sel_changes);
    $display("%0d rises held by hysteresis, %0d samples with no matching entry.",
             rises_held, no_match);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ccts_pkg.sv
design/ccts_regs.sv
design/ccts_match.sv
design/ccts_hyst.sv
design/charge_current_table_select_top.sv
tb/charge_current_table_select_top_tb.sv
